// ===== design/crcfr_pkg.sv =====
package crcfr_pkg;

  // Stream payload widths.
  localparam int unsigned RxByteW   = 8;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned PayloadW  = 32;
  localparam int unsigned CrcW      = 16;
  localparam int unsigned ResultW   = 1 + AddrW + PayloadW;
  localparam int unsigned OutTdataW = ((ResultW + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Body bytes after the two header bytes, and the counter that walks them.
  localparam int unsigned BodyBytes = 8;
  localparam int unsigned BodyIdxW  = $clog2(BodyBytes);

  // CRC-16/Modbus constants.
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_EXP_DEVICE = 1'b0,
    REG_EXP_FUNC   = 1'b1
  } cfg_reg_e;

  // Frame parser phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_FUNC = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  // Body byte positions.
  localparam logic [BodyIdxW-1:0] IdxPayloadFirst = 3'd2;
  localparam logic [BodyIdxW-1:0] IdxCrcFirst     = 3'd6;
  localparam logic [BodyIdxW-1:0] IdxLast         = 3'd7;

  // One result transaction.
  typedef struct packed {
    logic [PayloadW-1:0] payload;
    logic [AddrW-1:0]    register_address;
    logic                crc_ok;
  } result_t;

  // Byte-wide reflected CRC update, eight shift steps unrolled.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [RxByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/crc_frame_receiver_top.sv =====
// Channel  | Direction | Payload (low bit first)
// ---------+-----------+----------------------------------------------------
// s_axis   | in        | tdata[7:0] rx_byte
// m_axis   | out       | tdata[0] crc_ok, [16:1] register_address,
//          |           |   [48:17] payload, [55:49] zero
// cfg      | in        | cfg_index_i 0 expected_device, 1 expected_func
//
// One byte is taken in every cycle unless the tenth is held off (below); the
// CRC update and field capture happen in the cycle of the transaction, and a
// result is shown from the output register the cycle after the tenth byte.
// Reset (rst_ni low, asynchronous) returns the parser to hunting and
// clears both configuration registers and the output valid.
// While a result waits on m_axis, bytes keep being taken; only the tenth
// byte of the next frame is held off until the output register is free.
module crc_frame_receiver_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Received byte stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [crcfr_pkg::RxByteW-1:0]   s_axis_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] crc_ok, [16:1] register_address, [48:17] payload, rest zero
  output logic [crcfr_pkg::OutTdataW-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [crcfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [crcfr_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import crcfr_pkg::*;

  // Configuration registers.
  logic [CfgDataW-1:0] exp_device_q;
  logic [CfgDataW-1:0] exp_func_q;

  // Parser state.
  phase_e              phase_q, phase_d;
  logic [BodyIdxW-1:0] idx_q, idx_d;
  logic [CrcW-1:0]     crc_q, crc_d;
  logic [AddrW-1:0]    addr_q, addr_d;
  logic [PayloadW-1:0] pay_q, pay_d;
  logic [CrcW-1:0]     chk_q, chk_d;

  // Output register.
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  logic    s_accept;
  logic    at_last;
  logic    emit;
  logic    crc_match;
  logic [CrcW-1:0] rx_chk;

  // The last body byte is the only one that needs room at the output.
  assign at_last       = (phase_q == PH_BODY) && (idx_q == IdxLast);
  assign s_axis_tready = !(at_last && out_valid_q && !m_axis_tready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign emit          = s_accept && at_last;

  // Received checksum after the final byte, big-endian.
  assign rx_chk    = {chk_q[7:0], s_axis_tdata};
  assign crc_match = (rx_chk == crc_q);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_device_q <= '0;
      exp_func_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_EXP_DEVICE: exp_device_q <= cfg_wdata_i;
        REG_EXP_FUNC:   exp_func_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state of the parser and the output register.
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    addr_d      = addr_q;
    pay_d       = pay_q;
    chk_d       = chk_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    // The consumer drains the output register.
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (s_accept) begin
      case (phase_q)
        PH_FUNC: begin
          if (s_axis_tdata == exp_func_q) begin
            crc_d   = crc_byte(crc_q, s_axis_tdata);
            idx_d   = '0;
            phase_d = PH_BODY;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          // Route the byte into its field's shift register.
          if (idx_q < IdxPayloadFirst) begin
            addr_d = {addr_q[AddrW-RxByteW-1:0], s_axis_tdata};
          end else if (idx_q < IdxCrcFirst) begin
            pay_d = {pay_q[PayloadW-RxByteW-1:0], s_axis_tdata};
          end else begin
            chk_d = rx_chk;
          end
          if (idx_q < IdxCrcFirst) begin
            crc_d = crc_byte(crc_q, s_axis_tdata);
          end
          if (idx_q == IdxLast) begin
            out_valid_d          = 1'b1;
            out_d.crc_ok         = crc_match;
            out_d.register_address = crc_match ? addr_q : '0;
            out_d.payload        = crc_match ? pay_q : '0;
            phase_d              = PH_HUNT;
            idx_d                = '0;
            crc_d                = CrcInit;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: begin
          // Hunting for the device byte; the unused code behaves the same.
          if (s_axis_tdata == exp_device_q) begin
            crc_d   = crc_byte(CrcInit, s_axis_tdata);
            phase_d = PH_FUNC;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      idx_q       <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Field shift registers and result payload.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    pay_q  <= pay_d;
    chk_q  <= chk_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - ResultW){1'b0}}, out_q};

  // The body counter only moves while collecting the body.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> (phase_q == PH_BODY))
    else $error("body index nonzero outside body phase");

  // A completed frame always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_axis_tvalid)
    else $error("completed frame produced no result");

  // A frame is never completed on top of an undelivered result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || m_axis_tready))
    else $error("result overwritten before transaction");

  // A failed check carries zeroed fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q.crc_ok) |->
      (out_q.register_address == '0 && out_q.payload == '0))
    else $error("failed frame carries nonzero fields");

endmodule

// ===== dv/crc_frame_receiver_top_tb.sv =====
`timescale 1ns / 1ps

module crc_frame_receiver_top_tb;
  import crcfr_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseBytes   = 225;
  localparam int unsigned IdlePercent  = 7;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned HoldAfter    = 30;
  localparam int unsigned CalmFirst    = 1000;
  localparam int unsigned CalmLast     = 1400;
  localparam int unsigned DrainCycles  = 8;

  // Tracks the frame parser and holds the results it still owes.
  class frame_scoreboard;
    logic [7:0]          exp_device;
    logic [7:0]          exp_func;
    phase_e              phase;
    logic [BodyIdxW-1:0] body_idx;
    logic [CrcW-1:0]     crc_acc;
    logic [AddrW-1:0]    addr_sr;
    logic [PayloadW-1:0] payload_sr;
    logic [CrcW-1:0]     chk_sr;
    result_t             pending[$];
    int unsigned         mismatches;

    function new();
      exp_device = '0;
      exp_func   = '0;
      phase      = PH_HUNT;
      body_idx   = '0;
      crc_acc    = CrcInit;
      addr_sr    = '0;
      payload_sr = '0;
      chk_sr     = '0;
      mismatches = 0;
    endfunction

    // Bitwise Modbus CRC, the data bit folded into the decision instead of
    // being xored into the register first.
    static function logic [CrcW-1:0] modbus_step(logic [CrcW-1:0] crc, logic [7:0] b);
      logic [CrcW-1:0] c;
      c = crc;
      for (int k = 0; k < 8; k++) begin
        c = (c[0] ^ b[k]) ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [7:0] value);
      if (idx == REG_EXP_DEVICE) begin
        exp_device = value;
      end else begin
        exp_func = value;
      end
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR at %0t: %s", $realtime, what);
      end
    endfunction

    // Advances the parser by one accepted byte.
    function void note_byte(logic [7:0] b);
      result_t r;
      case (phase)
        PH_FUNC: begin
          if (b == exp_func) begin
            crc_acc  = modbus_step(crc_acc, b);
            body_idx = '0;
            phase    = PH_BODY;
          end else begin
            // The mismatched byte is not retried as a device byte.
            phase = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (body_idx < IdxPayloadFirst) begin
            addr_sr = {addr_sr[7:0], b};
          end else if (body_idx < IdxCrcFirst) begin
            payload_sr = {payload_sr[23:0], b};
          end else begin
            chk_sr = {chk_sr[7:0], b};
          end
          if (body_idx < IdxCrcFirst) begin
            crc_acc = modbus_step(crc_acc, b);
          end
          if (body_idx == IdxLast) begin
            r.crc_ok           = (chk_sr == crc_acc);
            r.register_address = r.crc_ok ? addr_sr : '0;
            r.payload          = r.crc_ok ? payload_sr : '0;
            pending.push_back(r);
            phase    = PH_HUNT;
            body_idx = '0;
            crc_acc  = CrcInit;
          end else begin
            body_idx++;
          end
        end
        default: begin
          if (b == exp_device) begin
            crc_acc = modbus_step(CrcInit, b);
            phase   = PH_FUNC;
          end else begin
            phase = PH_HUNT;
          end
        end
      endcase
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(logic [OutTdataW-1:0] tdata);
      result_t got;
      result_t want;
      got = tdata[ResultW-1:0];
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result, tdata %h", tdata));
        return;
      end
      want = pending.pop_front();
      if (got.crc_ok !== want.crc_ok || got.register_address !== want.register_address ||
          got.payload !== want.payload || tdata[OutTdataW-1:ResultW] !== '0) begin
        flag($sformatf("crc_ok exp %0d got %0d, address exp %h got %h, payload exp %h got %h, pad %h",
                       want.crc_ok, got.crc_ok, want.register_address,
                       got.register_address, want.payload, got.payload,
                       tdata[OutTdataW-1:ResultW]));
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [RxByteW-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;

  frame_scoreboard sb;
  int unsigned     cycle_count;
  int unsigned     results_seen;
  int unsigned     bytes_sent;
  int unsigned     hold_left;
  bit              held_once;
  logic [7:0]      cur_dev;
  logic [7:0]      cur_func;
  wire             calm = (cycle_count >= CalmFirst) && (cycle_count < CalmLast);

  crc_frame_receiver_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    // [0] crc_ok, [16:1] register_address, [48:17] payload, rest zero
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog on the cycle count.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Mismatches found");
    $finish;
  end

  // Result receiver: random back-pressure, one long hold once traffic is flowing.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if (!held_once && results_seen >= HoldAfter) begin
      held_once     = 1'b1;
      hold_left     = LongHold;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      sb.check_result(m_axis_tdata);
    end
  end

  // Offers one byte and waits for its transaction.
  task automatic send_rx_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Sends a full frame; a corrupted frame carries a wrong checksum.
  task automatic send_frame(input logic [7:0] dev, input logic [7:0] func,
                            input logic [15:0] addr, input logic [31:0] data,
                            input bit corrupt);
    logic [7:0]  body[8];
    logic [15:0] crc;
    body = '{dev, func, addr[15:8], addr[7:0], data[31:24], data[23:16], data[15:8], data[7:0]};
    crc  = CrcInit;
    foreach (body[k]) begin
      crc = frame_scoreboard::modbus_step(crc, body[k]);
      send_rx_byte(body[k]);
    end
    if (corrupt) begin
      crc ^= 16'($urandom_range(16'hFFFF, 1));
    end
    send_rx_byte(crc[15:8]);
    send_rx_byte(crc[7:0]);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Stops offering bytes, lets the block drain, then sets both header registers.
  task automatic program_regs(input logic [7:0] dev, input logic [7:0] func);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(REG_EXP_DEVICE, dev);
    write_reg(REG_EXP_FUNC, func);
    cur_dev  = dev;
    cur_func = func;
  endtask

  // Mostly well-formed frames, with bad checksums, broken headers and noise mixed in.
  task automatic random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(cur_dev, cur_func, 16'($urandom), $urandom, 1'b0);
      end else if (pick < 80) begin
        send_frame(cur_dev, cur_func, 16'($urandom), $urandom, 1'b1);
      end else if (pick < 88) begin
        send_rx_byte(cur_dev);
        send_rx_byte((pick & 1) ? cur_dev : (cur_func ^ 8'($urandom_range(255, 1))));
      end else begin
        repeat ($urandom_range(4, 1)) send_rx_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] dev_list[5];
    logic [7:0] func_list[5];
    sb            = new();
    cycle_count   = 0;
    results_seen  = 0;
    bytes_sent    = 0;
    hold_left     = 0;
    held_once     = 1'b0;
    cur_dev       = '0;
    cur_func      = '0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_EXP_DEVICE;
    cfg_wdata_i   = '0;
    dev_list      = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'($urandom)};
    func_list     = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'($urandom)};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, a checksum mismatch, and a wrong function code
    // that equals the device number and must not restart a header.
    program_regs(8'h01, 8'h03);
    send_frame(8'h01, 8'h03, 16'h0000, 32'h0000_0000, 1'b0);
    send_frame(8'h01, 8'h03, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_rx_byte(8'h01);
    send_rx_byte(8'h01);
    send_rx_byte(8'h03);
    send_rx_byte(8'hFF);
    send_rx_byte(8'h00);

    // Random traffic under several header settings, extremes included.
    for (int p = 0; p < 5; p++) begin
      program_regs(dev_list[p], func_list[p]);
      random_traffic(PhaseBytes);
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/crcfr_pkg.sv
design/crc_frame_receiver_top.sv
dv/crc_frame_receiver_top_tb.sv
